// ----- rtl/pct_pkg.sv -----
// Package for the percent escape decoder: payload types, escape phase codes,
// character constants and the hex digit decode functions.
// Depends on nothing; the top level, the input register and the core import it.
package pct_pkg;

   localparam logic [7:0] PCT_CHAR     = 8'h25;
   localparam logic [7:0] SPACE_CHAR   = 8'h20;
   localparam int         NIBBLE_WIDTH = 4;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      PHASE_TEXT  = 3'b001,
      PHASE_PCT   = 3'b010,
      PHASE_DIGIT = 3'b100
   } phase_type;

   typedef struct packed {
      logic                    bad;
      logic                    space;
      logic [NIBBLE_WIDTH-1:0] value;
   } digit_info_type;

   function automatic digit_info_type digit_class(input logic [7:0] c);
      digit_info_type info;
      info.bad   = 1'b0;
      info.space = 1'b0;
      info.value = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         info.value = NIBBLE_WIDTH'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         info.value = NIBBLE_WIDTH'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         info.value = NIBBLE_WIDTH'(c - 8'h57);
      end else if (c == SPACE_CHAR) begin
         info.space = 1'b1;
      end else begin
         info.bad = 1'b1;
      end
      return info;
   endfunction

   // A space contributes no digit; any other non-hex character zeroes the result.
   function automatic logic [7:0] decode_pair(input logic [7:0] c1, input logic [7:0] c2);
      digit_info_type d1;
      digit_info_type d2;
      logic [7:0]     result;
      d1 = digit_class(c1);
      d2 = digit_class(c2);
      if (d1.bad || d2.bad) begin
         result = 8'h00;
      end else if (d1.space && d2.space) begin
         result = 8'h00;
      end else if (d1.space) begin
         result = {{NIBBLE_WIDTH{1'b0}}, d2.value};
      end else if (d2.space) begin
         result = {{NIBBLE_WIDTH{1'b0}}, d1.value};
      end else begin
         result = {d1.value, d2.value};
      end
      return result;
   endfunction

endpackage

// ----- rtl/pct_stream_if.sv -----
// Valid/ready stream interface used for both channels of the decoder.
// The payload type is set where the interface is instantiated.
// Depends on nothing; payload types come from pct_pkg at the instantiation.
interface pct_stream_if #(
   parameter type payload_type = logic [7:0]
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/percent_escape_decoder.sv -----
// Top level of the URL percent escape decoder.
// Depends on pct_pkg, pct_stream_if, pct_in_reg and pct_core.
//
// Usage:
//   req_ch carries one text byte per transaction (in_byte, in_last marks the
//   final byte of a string). rsp_ch carries decoded bytes (out_byte, out_last).
//   A '%' and the byte after it produce no result; the third byte of an escape
//   produces the decoded byte. A '%' at or just before the end of the string
//   passes through unchanged, so the last byte of the string can produce two
//   results.
//   The result of an accepted byte passes the input register, then the result
//   queue, before it is valid on rsp_ch.
//   Throughput: one byte per cycle while rsp_ch takes results. A byte that
//   yields two results is taken only when two queue entries are free, counting
//   an entry that leaves in the same cycle; behind a full queue it waits.
//   Reset clears the input register, the escape phase and the result queue.
//   When the receiver stalls, the two-entry queue and the input register fill
//   and req_ch.ready drops; no transaction is lost.
module percent_escape_decoder (
   input logic          clock,
   input logic          reset,
   pct_stream_if.sink   req_ch,
   pct_stream_if.source rsp_ch
);
   import pct_pkg::*;

   logic            item_valid;
   logic            item_take;
   req_payload_type item;

   pct_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   pct_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ----- rtl/pct_in_reg.sv -----
// Input register of the decoder: holds one request transaction until the
// core takes it. Depends on pct_pkg and pct_stream_if.
module pct_in_reg (
   input  logic                     clock,
   input  logic                     reset,
   pct_stream_if.sink               req_ch,
   output logic                     item_valid,
   output pct_pkg::req_payload_type item,
   input  logic                     item_take
);
   import pct_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   req_payload_type item_ff;
   logic            accept;

   assign req_ch.ready = !valid_ff || item_take;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_ch.payload;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ----- rtl/pct_core.sv -----
// Escape state machine, digit decode and two-entry result queue.
// Depends on pct_pkg and pct_stream_if.
module pct_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  pct_pkg::req_payload_type item,
   output logic                     item_take,
   pct_stream_if.source             rsp_ch
);
   import pct_pkg::*;

   phase_type       phase_ff;
   phase_type       phase_in;
   logic [7:0]      first_ff;
   logic [7:0]      first_in;
   rsp_payload_type entry0_ff;
   rsp_payload_type entry1_ff;
   rsp_payload_type entry0_in;
   rsp_payload_type entry1_in;
   logic [1:0]      count_ff;
   logic [1:0]      count_in;

   rsp_payload_type res0;
   rsp_payload_type res1;
   logic [1:0]      need;
   logic [1:0]      free;
   logic [1:0]      rem_count;
   rsp_payload_type rem0;
   logic            pop;

   // Results and next phase for the item at the head of the input register.
   always_comb begin
      res0     = '{out_byte: item.in_byte, out_last: item.in_last};
      res1     = '{out_byte: item.in_byte, out_last: 1'b1};
      need     = 2'd0;
      phase_in = phase_ff;
      first_in = first_ff;
      unique case (phase_ff)
         PHASE_PCT: begin
            if (item.in_last) begin
               res0     = '{out_byte: PCT_CHAR, out_last: 1'b0};
               need     = 2'd2;
               phase_in = PHASE_TEXT;
            end else begin
               first_in = item.in_byte;
               phase_in = PHASE_DIGIT;
            end
         end
         PHASE_DIGIT: begin
            res0     = '{out_byte: decode_pair(first_ff, item.in_byte),
                         out_last: item.in_last};
            need     = 2'd1;
            phase_in = PHASE_TEXT;
         end
         default: begin
            if (item.in_byte == PCT_CHAR && !item.in_last) begin
               phase_in = PHASE_PCT;
            end else begin
               need     = 2'd1;
               phase_in = PHASE_TEXT;
            end
         end
      endcase
   end

   assign pop       = rsp_ch.valid && rsp_ch.ready;
   assign free      = 2'd2 - count_ff + {1'b0, pop};
   assign item_take = item_valid && (need <= free);

   // Queue update: drop the head if it leaves, then append the new results.
   // An item that yields nothing must leave the held entries untouched.
   always_comb begin
      rem_count = count_ff - {1'b0, pop};
      rem0      = pop ? entry1_ff : entry0_ff;
      entry0_in = rem0;
      entry1_in = entry1_ff;
      count_in  = rem_count;
      if (item_take && need != 2'd0) begin
         count_in = rem_count + need;
         if (rem_count == 2'd0) begin
            entry0_in = res0;
            entry1_in = res1;
         end else begin
            entry1_in = res0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_TEXT;
         first_ff <= 8'h00;
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (item_take) begin
            phase_ff <= phase_in;
            first_ff <= first_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry0_ff <= entry0_in;
      entry1_ff <= entry1_in;
   end

   assign rsp_ch.valid   = (count_ff != 2'd0);
   assign rsp_ch.payload = entry0_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_room_for_results: assert property (@(posedge clock) disable iff (reset)
      item_take |-> (count_ff - {1'b0, pop} + need) <= 2'd2)
      else $error("item taken without room for its results");

   a_pct_then_digit: assert property (@(posedge clock) disable iff (reset)
      (item_take && phase_ff == PHASE_PCT && !item.in_last) |=> phase_ff == PHASE_DIGIT)
      else $error("first digit did not advance the escape phase");

   a_pair_fills_queue: assert property (@(posedge clock) disable iff (reset)
      (item_take && need == 2'd2 && !pop) |=> count_ff == 2'd2)
      else $error("two results were not both queued");

endmodule
